// ----- hw/rtl/event_flag_group_waiter_table_defines.svh -----
// Assertion macros shared by the event flag group RTL.
`ifndef EVENT_FLAG_GROUP_WAITER_TABLE_DEFINES_SVH
`define EVENT_FLAG_GROUP_WAITER_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define EFG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EFG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/efg_pkg.sv -----
// Types and codes shared by the event flag group block.
package efg_pkg;
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_WAIT  = 2'd2;
  localparam logic [1:0] MODE_TMO   = 2'd3;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_WOKEN   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5,
    ST_DONE    = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] flag_mask;
    logic [3:0]  task_id;
    logic [7:0]  priority_req;
    logic        match_all;
    logic        clr_on_hit;
    logic        no_wait;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  task_id_out;
    logic [31:0] matched_bits;
    logic [31:0] event_bits_now;
    logic        last;
  } out_word_t;

  // One waiter entry as held in the table memory.
  typedef struct packed {
    logic [3:0]  task_id;
    logic [7:0]  prio;
    logic [31:0] mask;
    logic        all;
    logic        clr;
  } entry_t;
endpackage

// ----- hw/rtl/event_flag_group_waiter_table.sv -----
// Event flag group with a priority-ordered table of waiting tasks.
//   channel | direction | payload    | handshake
//   in      | input     | in_word_t  | in_valid_i / in_stall_o
//   out     | output    | out_word_t | out_valid_o / out_stall_i
// A word that needs no table access passes through decode, emit and idle from
// acceptance to the next acceptance.
// A scan reads the entries one at a time. Removing an entry copies each following
// entry down by a read and a write; inserting copies each entry up by a read and a write.
// Each further result word of a set passes through the emit state again.
// Reset clears the event word and the entry count; table entries are not cleared.
// A stalled output word holds the sequencer in its emit state until it is taken.
module event_flag_group_waiter_table import efg_pkg::*; #(
  parameter int MAX_WAITERS = 8,
  parameter int FLAG_BITS   = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);
  `include "event_flag_group_waiter_table_defines.svh"

  localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CW = $clog2(MAX_WAITERS + 1);
  localparam logic [31:0] WMASK = (FLAG_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << FLAG_BITS) - 64'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1; // decode the word; decide words that need no table access
  localparam logic [2:0] S_CHK  = 3'd2; // data of entry idx valid
  localparam logic [2:0] S_SHRD = 3'd3; // removal: read sh+1
  localparam logic [2:0] S_SHWR = 3'd4; // removal: write sh from sh+1
  localparam logic [2:0] S_UPRD = 3'd5; // insertion: read sh-1 or write new entry
  localparam logic [2:0] S_UPWR = 3'd6; // insertion: write sh from sh-1
  localparam logic [2:0] S_EMIT = 3'd7; // hand pending result to the output

  logic [2:0]    st_q, st_d;
  in_word_t      req_q, req_d;
  logic [31:0]   ev_q, ev_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;   // scan position
  logic [CW-1:0] sh_q, sh_d;     // shift position
  logic [CW-1:0] pos_q, pos_d;   // insert position
  out_word_t     pend_q, pend_d;
  out_word_t     ob_q, ob_d;
  logic          ov_q, ov_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata, ne;

  efg_table_ram #(.Depth(MAX_WAITERS), .AddrW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [31:0]   msk, sel, e_sel, ev_hit;
  logic          hit_ok, e_ok, tid_eq, last_ent;
  logic [CW-1:0] idx_nx, sh_nx, sh_pv, pos_n;

  always_comb begin
    msk      = req_q.flag_mask & WMASK;
    sel      = ev_q & msk;
    hit_ok   = req_q.match_all ? (sel == msk) : (sel != 32'd0);
    e_sel    = ev_q & rdata.mask;
    e_ok     = rdata.all ? (e_sel == rdata.mask) : (e_sel != 32'd0);
    ev_hit   = rdata.clr ? (ev_q & ~e_sel) : ev_q;
    tid_eq   = (rdata.task_id == req_q.task_id);
    idx_nx   = idx_q + CW'(1);
    sh_nx    = sh_q + CW'(1);
    sh_pv    = sh_q - CW'(1);
    last_ent = (idx_nx >= cnt_q);
    // The table is sorted, so the first lower priority marks the insert slot.
    pos_n    = (pos_q == cnt_q && rdata.prio < req_q.priority_req) ? idx_q : pos_q;
    ne.task_id = req_q.task_id;
    ne.prio    = req_q.priority_req;
    ne.mask    = msk;
    ne.all     = req_q.match_all;
    ne.clr     = req_q.clr_on_hit;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = ob_q;

  always_comb begin
    st_d = st_q; req_d = req_q; ev_d = ev_q; cnt_d = cnt_q; idx_d = idx_q;
    sh_d = sh_q; pos_d = pos_q; pend_d = pend_q; ob_d = ob_q; ov_d = ov_q;
    we = 1'b0; waddr = sh_q[AW-1:0]; raddr = idx_q[AW-1:0]; wdata = rdata;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i; idx_d = '0; st_d = S_DEC;
        end
      end
      S_DEC: begin
        pend_d.status = ST_DONE; pend_d.task_id_out = req_q.task_id;
        pend_d.matched_bits = '0; pend_d.event_bits_now = ev_q; pend_d.last = 1'b1;
        pos_d = cnt_q; st_d = S_EMIT;
        case (req_q.mode)
          MODE_SET: begin
            if (msk == '0) begin
              pend_d.status = ST_INVALID;
            end else begin
              ev_d = ev_q | msk; pend_d.event_bits_now = ev_q | msk;
              if (cnt_q != '0) st_d = S_CHK;
            end
          end
          MODE_CLEAR: begin
            ev_d = ev_q & ~msk; pend_d.event_bits_now = ev_q & ~msk;
          end
          MODE_WAIT: begin
            if (msk == '0) begin
              pend_d.status = ST_INVALID;
            end else if (hit_ok) begin
              ev_d = req_q.clr_on_hit ? (ev_q & ~sel) : ev_q;
              pend_d.status = ST_MATCHED; pend_d.matched_bits = sel;
              pend_d.event_bits_now = req_q.clr_on_hit ? (ev_q & ~sel) : ev_q;
            end else if (req_q.no_wait) begin
              pend_d.status = ST_TIMEOUT;
            end else if (cnt_q == '0) begin
              sh_d = '0; st_d = S_UPRD;
            end else begin
              st_d = S_CHK;
            end
          end
          default: begin
            if (cnt_q != '0) st_d = S_CHK;
          end
        endcase
      end
      S_CHK: begin
        pend_d.status = ST_DONE; pend_d.task_id_out = req_q.task_id;
        pend_d.matched_bits = '0; pend_d.event_bits_now = ev_q; pend_d.last = 1'b1;
        if (req_q.mode == MODE_SET) begin
          if (e_ok) begin
            ev_d = ev_hit;
            pend_d.status = ST_WOKEN; pend_d.task_id_out = rdata.task_id;
            pend_d.matched_bits = e_sel; pend_d.event_bits_now = ev_hit;
            pend_d.last = 1'b0; sh_d = idx_q; st_d = S_SHRD;
          end else if (last_ent) begin
            st_d = S_EMIT;
          end else begin
            idx_d = idx_nx; raddr = idx_nx[AW-1:0];
          end
        end else if (tid_eq) begin
          sh_d = idx_q;
          if (req_q.mode == MODE_TMO) begin
            pend_d.status = ST_TIMEOUT; st_d = S_SHRD;
          end else begin
            pend_d.status = ST_INVALID; st_d = S_EMIT;
          end
        end else begin
          pos_d = pos_n;
          if (last_ent) begin
            if (req_q.mode == MODE_TMO) begin
              st_d = S_EMIT;
            end else if (cnt_q == CW'(MAX_WAITERS)) begin
              pend_d.status = ST_FULL; st_d = S_EMIT;
            end else begin
              sh_d = cnt_q; st_d = S_UPRD;
            end
          end else begin
            idx_d = idx_nx; raddr = idx_nx[AW-1:0];
          end
        end
      end
      S_SHRD: begin
        // Close the gap at sh by copying the following entries down.
        if (sh_nx >= cnt_q) begin
          cnt_d = cnt_q - CW'(1); st_d = S_EMIT;
        end else begin
          raddr = sh_nx[AW-1:0]; st_d = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1; wdata = rdata; sh_d = sh_nx; st_d = S_SHRD;
      end
      S_UPRD: begin
        if (sh_q == pos_q) begin
          we = 1'b1; wdata = ne; cnt_d = cnt_q + CW'(1);
          pend_d.status = ST_BLOCKED; st_d = S_EMIT;
        end else begin
          raddr = sh_pv[AW-1:0]; st_d = S_UPWR;
        end
      end
      S_UPWR: begin
        we = 1'b1; wdata = rdata; sh_d = sh_pv; st_d = S_UPRD;
      end
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          ob_d = pend_q; ov_d = 1'b1;
          if (pend_q.last) begin
            st_d = S_IDLE;
          end else if (idx_q >= cnt_q) begin
            // The set scan has reached the end of the table.
            pend_d.status = ST_DONE; pend_d.task_id_out = req_q.task_id;
            pend_d.matched_bits = '0; pend_d.event_bits_now = ev_q;
            pend_d.last = 1'b1;
          end else begin
            st_d = S_CHK;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ev_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      idx_q <= '0; sh_q <= '0; pos_q <= '0;
      req_q <= '0; pend_q <= '0; ob_q <= '0;
    end else begin
      st_q <= st_d; ev_q <= ev_d; cnt_q <= cnt_d; ov_q <= ov_d;
      idx_q <= idx_d; sh_q <= sh_d; pos_q <= pos_d;
      req_q <= req_d; pend_q <= pend_d; ob_q <= ob_d;
    end
  end

  `EFG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_WAITERS))
  `EFG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, ov_q && out_stall_i, ov_q && $stable(ob_q))
  `EFG_ASSERT_NXT(a_accept_dec, clk_i, rst_ni, in_valid_i && !in_stall_o, st_q == S_DEC)
endmodule

// ----- hw/rtl/efg_table_ram.sv -----
// Waiter table memory: one write port, one registered read port.
module efg_table_ram import efg_pkg::*; #(
  parameter int Depth = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);
  entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
